>>> hw/rtl/dhs_pkg.sv
package dhs_pkg;

	localparam int SLOTS    = 1024;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int LEN_W    = SLOT_W + 1;
	localparam int KEY_BITS = 32;
	localparam int PAY_W    = 32;
	localparam int HASH_W   = 32;
	localparam int SP_W     = 10;
	localparam int ENT_W    = 1 + KEY_BITS + PAY_W;
	localparam int DIV_CNT_W = $clog2(HASH_W);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(11);
	localparam logic [SP_W-1:0]  SP_RESET  = SP_W'(7);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_DELETED  = 3'd4,
		ST_FULL     = 3'd5,
		ST_CLEARED  = 3'd6
	} status_t;

	typedef enum logic [0:0] {
		CFG_LENGTH = 1'd0,
		CFG_PRIME  = 1'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DOP_FIRST = 2'd0,
		DOP_STEP  = 2'd1,
		DOP_WRAP  = 2'd2
	} div_op_t;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_ADV,
		S_RD,
		S_CHK,
		S_RESP
	} state_t;

endpackage

>>> hw/rtl/dhs_ram.sv
module dhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/double_hashing_set_top.sv
// channel | direction | word                                         | handshake
// request | in        | req_type, item_key, key_hash, item_payload   | in_valid / in_ready
// result  | out       | status, payload_out, slot_index, entry_count | out_valid / out_ready
// config  | in        | cfg_index, cfg_data                          | cfg_we, no wait
//
// Insert, delete and lookup: three remainders in the shared remainder unit (hash mod length,
// hash mod second prime, step mod length), then probes over the slot RAM, each through
// the advance, read and check states; up to table_length probes.
// Clear and reset: one slot per cycle over all 1024 slots; no request taken meanwhile.
// A result waiting on out_ready holds the block in its response state.
module double_hashing_set_top
	import dhs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [KEY_BITS-1:0] item_key,
	input  logic [HASH_W-1:0]   key_hash,
	input  logic [PAY_W-1:0]    item_payload,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [PAY_W-1:0]    payload_out,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [LEN_W-1:0]    entry_count,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [LEN_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [LEN_W-1:0]    tl_q;
	logic [SP_W-1:0]     sp_q;
	logic [LEN_W-1:0]    len_q;
	logic [SP_W-1:0]     bp_q;
	logic [LEN_W-1:0]    count_q;
	req_t                req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [HASH_W-1:0]   hash_q;
	logic [PAY_W-1:0]    pay_q;

	logic [HASH_W-1:0]    dvd_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	div_op_t              op_q;
	logic [SLOT_W-1:0]    f_q;
	logic [SLOT_W-1:0]    stp_q;
	logic [SLOT_W-1:0]    pos_q;
	logic [LEN_W-1:0]     n_q;
	logic [SLOT_W-1:0]    clr_cnt_q;
	logic                 clr_req_q;

	status_t           res_st_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic              out_valid_q;
	status_t           out_st_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [LEN_W-1:0]  out_cnt_q;

	// request setup
	logic             accept;
	logic [LEN_W-1:0] len_eff;
	logic [SP_W-1:0]  bp_eff;

	// remainder unit
	logic [LEN_W-1:0]  dvs;
	logic [LEN_W-1:0]  rtry;
	logic [SLOT_W-1:0] rem_new;
	logic              div_last;
	logic [SP_W-1:0]   step_raw;

	// probe
	logic [LEN_W-1:0]  adv_sum;
	logic [SLOT_W-1:0] pos_adv;
	logic [ENT_W-1:0]  rd_ent;
	logic              rd_v;
	logic [KEY_BITS-1:0] rd_key;
	logic [PAY_W-1:0]  rd_pay;
	logic              key_eq;
	logic              hit;
	logic              last_probe;
	logic              resp_go;

	// slot RAM controls
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              ram_re;

	assign accept  = in_valid && in_ready;
	assign len_eff = (tl_q == '0) ? LEN_W'(1) :
		(tl_q > LEN_W'(SLOTS)) ? LEN_W'(SLOTS) : tl_q;
	assign bp_eff  = (sp_q == '0) ? SP_W'(1) : sp_q;

	always_comb begin
		unique case (op_q)
			DOP_STEP: dvs = {{(LEN_W-SP_W){1'b0}}, bp_q};
			default:  dvs = len_q;
		endcase
	end

	assign rtry     = {rem_q, dvd_q[HASH_W-1]};
	assign rem_new  = (rtry >= dvs) ? SLOT_W'(rtry - dvs) : SLOT_W'(rtry);
	assign div_last = (dcnt_q == DIV_CNT_W'(HASH_W - 1));
	assign step_raw = bp_q - SP_W'(rem_new);

	assign adv_sum = {1'b0, pos_q} + {1'b0, stp_q};
	assign pos_adv = (adv_sum >= len_q) ? SLOT_W'(adv_sum - len_q) : SLOT_W'(adv_sum);

	assign rd_v   = rd_ent[ENT_W-1];
	assign rd_key = rd_ent[PAY_W +: KEY_BITS];
	assign rd_pay = rd_ent[PAY_W-1:0];
	assign key_eq = (rd_key == key_q);
	assign hit    = (req_q == REQ_INSERT) ? (!rd_v || key_eq) : (rd_v && key_eq);
	assign last_probe = ((n_q + LEN_W'(1)) == len_q);
	assign resp_go    = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_cnt_q == SLOT_W'(SLOTS - 1)) begin
					state_d = clr_req_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req_t'(req_type) == REQ_CLEAR) begin
						state_d = S_CLR;
					end else if (req_t'(req_type) == REQ_INSERT && count_q >= len_eff) begin
						state_d = S_RESP;
					end else begin
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (div_last && op_q == DOP_WRAP) begin
					state_d = S_ADV;
				end
			end
			S_ADV: state_d = S_RD;
			S_RD:  state_d = S_CHK;
			S_CHK: begin
				state_d = (hit || last_probe) ? S_RESP : S_ADV;
			end
			S_RESP: begin
				if (resp_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = {1'b1, key_q, pay_q};
		ram_re    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			S_IDLE: in_ready = 1'b1;
			S_RD:   ram_re = 1'b1;
			S_CHK: begin
				if (hit) begin
					unique case (req_q)
						REQ_INSERT: ram_we = 1'b1;
						REQ_DELETE: begin
							ram_we    = 1'b1;
							ram_wdata = {1'b0, rd_key, rd_pay};
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	dhs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			tl_q        <= LEN_RESET;
			sp_q        <= SP_RESET;
			count_q     <= '0;
			clr_cnt_q   <= '0;
			clr_req_q   <= 1'b0;
			dcnt_q      <= '0;
			op_q        <= DOP_FIRST;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LENGTH: tl_q <= cfg_data;
					CFG_PRIME:  sp_q <= cfg_data[SP_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_RESP && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
					if (clr_cnt_q == SLOT_W'(SLOTS - 1) && clr_req_q) begin
						count_q    <= '0;
						clr_req_q  <= 1'b0;
						res_st_q   <= ST_CLEARED;
						res_pay_q  <= '0;
						res_slot_q <= '0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						req_q  <= req_t'(req_type);
						key_q  <= item_key;
						hash_q <= key_hash;
						pay_q  <= item_payload;
						len_q  <= len_eff;
						bp_q   <= bp_eff;
						dvd_q  <= key_hash;
						rem_q  <= '0;
						dcnt_q <= '0;
						op_q   <= DOP_FIRST;
						res_st_q   <= ST_FULL;
						res_pay_q  <= '0;
						res_slot_q <= '0;
						if (req_t'(req_type) == REQ_CLEAR) begin
							clr_req_q <= 1'b1;
							clr_cnt_q <= '0;
						end
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						rem_q <= '0;
						unique case (op_q)
							DOP_FIRST: begin
								f_q   <= rem_new;
								dvd_q <= hash_q;
								op_q  <= DOP_STEP;
							end
							DOP_STEP: begin
								dvd_q <= {{(HASH_W-SP_W){1'b0}}, step_raw};
								op_q  <= DOP_WRAP;
							end
							DOP_WRAP: begin
								stp_q <= rem_new;
								pos_q <= f_q;
								n_q   <= '0;
								op_q  <= DOP_FIRST;
							end
							default: op_q <= DOP_FIRST;
						endcase
					end else begin
						dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
						rem_q <= rem_new;
					end
				end
				S_ADV: pos_q <= pos_adv;
				S_CHK: begin
					n_q <= n_q + LEN_W'(1);
					if (hit) begin
						res_slot_q <= pos_q;
						unique case (req_q)
							REQ_INSERT: begin
								if (!rd_v) begin
									res_st_q  <= ST_INSERTED;
									res_pay_q <= '0;
									count_q   <= count_q + LEN_W'(1);
								end else begin
									res_st_q  <= ST_REPLACED;
									res_pay_q <= rd_pay;
								end
							end
							REQ_DELETE: begin
								res_st_q  <= ST_DELETED;
								res_pay_q <= rd_pay;
								if (count_q != '0) begin
									count_q <= count_q - LEN_W'(1);
								end
							end
							default: begin
								res_st_q  <= ST_FOUND;
								res_pay_q <= rd_pay;
							end
						endcase
					end else if (last_probe) begin
						res_st_q <= (req_q == REQ_INSERT) ? ST_FULL : ST_MISSING;
					end
				end
				S_RESP: begin
					if (resp_go) begin
						out_st_q    <= res_st_q;
						out_pay_q   <= res_pay_q;
						out_slot_q  <= res_slot_q;
						out_cnt_q   <= count_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign payload_out = out_pay_q;
	assign slot_index  = out_slot_q;
	assign entry_count = out_cnt_q;

endmodule

>>> hw/rtl/dhs_check.sv
module dhs_check
	import dhs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [2:0]          status,
	input logic [PAY_W-1:0]    payload_out,
	input logic [SLOT_W-1:0]   slot_index,
	input logic [LEN_W-1:0]    entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_out)
			&& $stable(slot_index) && $stable(entry_count))
		else $error("result word changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLEARED |-> entry_count == '0)
		else $error("clear left entries");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_MISSING || status == ST_CLEARED)
			|-> payload_out == '0 && slot_index == '0)
		else $error("no-slot result carries data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= LEN_W'(SLOTS) && status != 3'd7)
		else $error("bad result word");

endmodule

bind double_hashing_set_top dhs_check u_dhs_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.payload_out (payload_out),
	.slot_index  (slot_index),
	.entry_count (entry_count)
);
